[design/rsm_pkg.sv]
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types and constants of the random sample multiset.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned RndW     = 32;
  localparam int unsigned DivCntW  = $clog2(RndW);
  localparam int unsigned EntryW   = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_SCAN   = 2'd0,
    RD_LAST   = 2'd1,
    RD_SAMPLE = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
    logic [31:0]        random_word;
  } req_t;

  typedef struct packed {
    logic               hit_flag;
    logic signed [31:0] sampled_value;
    logic [1:0]         status_code;
    logic [EntryW-1:0]  entry_count;
  } res_t;

  typedef struct packed {
    logic    capture;
    logic    scan;
    logic    div_step;
    rd_sel_e rd_sel;
    logic    wr_insert;
    logic    wr_move;
    logic    take_sample;
    logic    set_full;
    logic    set_empty;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       scan_end;
    logic       found;
    logic       div_last;
  } sts_t;

endpackage

[design/rsm_ctrl.sv]
// ----------------------------------------------------------------------------
// rsm_ctrl
// Request sequencer: decodes a captured request and steps the datapath
// through scan, write, modulo and read phases.
// ----------------------------------------------------------------------------
module rsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rsm_pkg::sts_t sts_i,
  output rsm_pkg::cmd_t cmd_o,
  output logic          busy,
  output logic          res_valid_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DECODE = 10'b00_0000_0010,
    S_SCAN   = 10'b00_0000_0100,
    S_WRITE  = 10'b00_0000_1000,
    S_RDLAST = 10'b00_0001_0000,
    S_MOVE   = 10'b00_0010_0000,
    S_DIV    = 10'b00_0100_0000,
    S_RDSMP  = 10'b00_1000_0000,
    S_GET    = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = rsm_pkg::RD_SCAN;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.kind == rsm_pkg::REQ_INSERT) begin
          if (sts_i.full) begin
            cmd_o.set_full = 1'b1;
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end else if (sts_i.kind == rsm_pkg::REQ_REMOVE) begin
          state_d = S_SCAN;
        end else if (sts_i.kind == rsm_pkg::REQ_SAMPLE) begin
          if (sts_i.empty) begin
            cmd_o.set_empty = 1'b1;
            state_d = S_RESP;
          end else begin
            state_d = S_DIV;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          if (sts_i.kind == rsm_pkg::REQ_INSERT) begin
            state_d = S_WRITE;
          end else if (sts_i.found) begin
            state_d = S_RDLAST;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_WRITE: begin
        cmd_o.wr_insert = 1'b1;
        state_d = S_RESP;
      end
      S_RDLAST: begin
        cmd_o.rd_sel = rsm_pkg::RD_LAST;
        state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.wr_move = 1'b1;
        state_d = S_RESP;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RDSMP;
        end
      end
      S_RDSMP: begin
        cmd_o.rd_sel = rsm_pkg::RD_SAMPLE;
        state_d = S_GET;
      end
      S_GET: begin
        cmd_o.take_sample = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

endmodule

[design/rsm_dpath.sv]
// ----------------------------------------------------------------------------
// rsm_dpath
// Entry store, occupancy count, match scan and bit-serial modulo unit.
// ----------------------------------------------------------------------------
module rsm_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsm_pkg::req_t req_i,
  input  rsm_pkg::cmd_t cmd_i,
  output rsm_pkg::sts_t sts_o,
  output rsm_pkg::res_t res_o
);

  localparam int unsigned ValW = rsm_pkg::VALUE_BITS;
  localparam int unsigned IdxW = rsm_pkg::IdxW;
  localparam int unsigned CntW = rsm_pkg::CntW;
  localparam int unsigned RndW = rsm_pkg::RndW;
  localparam int unsigned DcW  = rsm_pkg::DivCntW;

  logic [ValW-1:0] mem_q [rsm_pkg::CAPACITY];
  logic [ValW-1:0] rd_data_q;
  logic [IdxW-1:0] rd_addr;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_idx_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_pend_q;
  logic            found_q;
  logic [IdxW-1:0] pos_q;

  logic [1:0]      kind_q;
  logic [ValW-1:0] val_q;
  logic [RndW-1:0] rnd_q;
  logic [IdxW-1:0] rem_q;
  logic [DcW-1:0]  div_cnt_q;

  logic               hit_q;
  logic [31:0]        sample_q;
  rsm_pkg::status_e   status_q;

  logic            scan_issue;
  logic            match;
  logic [IdxW:0]   rem_sh;
  logic [IdxW:0]   cnt_ext;
  logic            rem_ge;
  logic [IdxW-1:0] rem_d;
  logic [CntW-1:0] last_idx;

  assign last_idx   = count_q - CntW'(1);
  assign scan_issue = cmd_i.scan && (scan_idx_q < count_q) && !found_q;
  assign match      = cmd_i.scan && rd_pend_q && !found_q && (rd_data_q == val_q);

  assign rem_sh  = {rem_q, rnd_q[RndW-1]};
  assign cnt_ext = (IdxW + 1)'(count_q);
  assign rem_ge  = (rem_sh >= cnt_ext);
  assign rem_d   = rem_ge ? IdxW'(rem_sh - cnt_ext) : IdxW'(rem_sh);

  always_comb begin
    case (cmd_i.rd_sel)
      rsm_pkg::RD_SCAN:   rd_addr = scan_idx_q[IdxW-1:0];
      rsm_pkg::RD_LAST:   rd_addr = last_idx[IdxW-1:0];
      rsm_pkg::RD_SAMPLE: rd_addr = rem_q;
      default:            rd_addr = scan_idx_q[IdxW-1:0];
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.wr_move) begin
      count_d = last_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_insert) begin
      mem_q[count_q[IdxW-1:0]] <= val_q;
    end else if (cmd_i.wr_move) begin
      mem_q[pos_q] <= rd_data_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_idx_q <= '0;
      rd_pend_q  <= 1'b0;
      found_q    <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.capture) begin
        scan_idx_q <= '0;
        rd_pend_q  <= 1'b0;
        found_q    <= 1'b0;
        div_cnt_q  <= '0;
      end else begin
        rd_pend_q <= scan_issue;
        if (scan_issue) begin
          scan_idx_q <= scan_idx_q + CntW'(1);
        end
        if (match) begin
          found_q <= 1'b1;
        end
        if (cmd_i.div_step) begin
          div_cnt_q <= div_cnt_q + DcW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr;
    if (match) begin
      pos_q <= rd_idx_q;
    end
    if (cmd_i.capture) begin
      kind_q   <= req_i.req_type;
      val_q    <= ValW'(req_i.item_value);
      rnd_q    <= req_i.random_word;
      rem_q    <= '0;
      hit_q    <= 1'b0;
      sample_q <= '0;
      status_q <= rsm_pkg::ST_OK;
    end else begin
      if (cmd_i.div_step) begin
        rem_q <= rem_d;
        rnd_q <= {rnd_q[RndW-2:0], 1'b0};
      end
      if (cmd_i.set_full) begin
        status_q <= rsm_pkg::ST_FULL;
      end
      if (cmd_i.set_empty) begin
        status_q <= rsm_pkg::ST_EMPTY;
      end
      if (cmd_i.wr_insert) begin
        hit_q <= !found_q;
      end
      if (cmd_i.wr_move) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.take_sample) begin
        sample_q <= 32'(rd_data_q);
      end
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.full     = (count_q == CntW'(rsm_pkg::CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.scan_end = found_q || ((scan_idx_q == count_q) && !rd_pend_q);
  assign sts_o.found    = found_q;
  assign sts_o.div_last = (div_cnt_q == DcW'(RndW - 1));

  assign res_o.hit_flag      = hit_q;
  assign res_o.sampled_value = sample_q;
  assign res_o.status_code   = status_q;
  assign res_o.entry_count   = rsm_pkg::EntryW'(count_q);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(rsm_pkg::CAPACITY))
    else $error("Occupancy exceeds capacity.");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_insert |-> (count_q < CntW'(rsm_pkg::CAPACITY)) && !found_q || !sts_o.full)
    else $error("Insert write issued while the store is full.");

  a_move_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_move |-> found_q && (count_q != '0) && ($past(cmd_i.rd_sel) == rsm_pkg::RD_LAST))
    else $error("Entry move without a match or without the last entry read.");

  a_sample_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_sel == rsm_pkg::RD_SAMPLE) |-> (CntW'(rem_q) < count_q))
    else $error("Sample index is not below the occupancy.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.wr_insert && !cmd_i.wr_move |=> $stable(count_q))
    else $error("Occupancy changed without a write.");
`endif

endmodule

[design/random_sample_multiset.sv]
// ----------------------------------------------------------------------------
// random_sample_multiset
// Bounded multiset of signed values with insert, remove and uniform sampling.
// ----------------------------------------------------------------------------
// A request is transferred on a rising edge where start is high and busy is
// low; req_i carries the request kind, the value and a random word. busy stays
// high until the single result has been presented.
// The result appears on res_o for exactly one cycle, marked by res_valid_o.
// The receiver cannot stall it, so it must take the transfer in that cycle.
// Insert and remove scan the store one entry per cycle through a single read
// port with registered data; the scan stops at the first match. After the
// scan an insert writes the value at the end of the store; a remove that
// found a match reads the last entry and moves it into the matched slot.
// A sample runs a 32-step bit-serial modulo of the random word by the
// occupancy and then reads one entry. Refused, empty and unused requests
// go from decode straight to the result. busy falls in the cycle after the
// result, so the next request can be transferred from that cycle on.
// One request is in flight at a time.
// Reset empties the store by clearing the occupancy; no clearing pass runs.
// ----------------------------------------------------------------------------
module random_sample_multiset (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rsm_pkg::req_t req_i,
  output logic          res_valid_o,
  output rsm_pkg::res_t res_o
);

  rsm_pkg::cmd_t cmd;
  rsm_pkg::sts_t sts;

  rsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy),
    .res_valid_o(res_valid_o)
  );

  rsm_dpath u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule

[verif/random_sample_multiset_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_sample_multiset_tb
// Self-checking testbench for the random sample multiset. Requests are sent
// with random gaps between them. A copy of the store inside the testbench
// works out each expected result, and every result is compared field by field
// against it. The run covers empty and full stores, duplicate values, the
// extreme values and a long random mix of inserts, removes and samples.
// ----------------------------------------------------------------------------
module random_sample_multiset_tb;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 1000;
  localparam int         TAIL_CYCLES = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  rsm_pkg::req_t req = '0;
  logic res_valid_o;
  rsm_pkg::res_t res_o;

  logic signed [31:0] stored_entries [rsm_pkg::CAPACITY];
  int unsigned        occupied_count = 0;
  rsm_pkg::res_t      expected_results [$];
  int                 mismatch_count = 0;
  int                 stall_cycles = 0;

  random_sample_multiset uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic rsm_pkg::res_t multiset_apply(rsm_pkg::req_t r);
    rsm_pkg::res_t res;
    int   slot;
    bit   found;
    res = '0;
    case (r.req_type)
      rsm_pkg::REQ_INSERT: begin
        if (occupied_count >= rsm_pkg::CAPACITY) begin
          res.status_code = rsm_pkg::ST_FULL;
        end else begin
          found = 1'b0;
          for (int i = 0; i < occupied_count; i++) begin
            if (stored_entries[i] == r.item_value) found = 1'b1;
          end
          res.hit_flag = !found;
          stored_entries[occupied_count] = r.item_value;
          occupied_count++;
        end
      end
      rsm_pkg::REQ_REMOVE: begin
        slot = -1;
        for (int i = 0; i < occupied_count; i++) begin
          if (slot < 0 && stored_entries[i] == r.item_value) slot = i;
        end
        if (slot >= 0) begin
          stored_entries[slot] = stored_entries[occupied_count - 1];
          occupied_count--;
          res.hit_flag = 1'b1;
        end
      end
      rsm_pkg::REQ_SAMPLE: begin
        if (occupied_count == 0) begin
          res.status_code = rsm_pkg::ST_EMPTY;
        end else begin
          res.sampled_value = stored_entries[r.random_word % occupied_count];
        end
      end
      default: ;
    endcase
    res.entry_count = occupied_count[rsm_pkg::EntryW-1:0];
    return res;
  endfunction

  function automatic rsm_pkg::req_t make_request(logic [1:0] kind,
                                                 logic signed [31:0] value,
                                                 logic [31:0] word);
    rsm_pkg::req_t r;
    r.req_type    = kind;
    r.item_value  = value;
    r.random_word = word;
    return r;
  endfunction

  // Values are drawn from the live entries, from a small pool that collides
  // often, or from the whole 32-bit range.
  function automatic rsm_pkg::req_t random_request(int insert_pct, int remove_pct);
    rsm_pkg::req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) r.req_type = rsm_pkg::REQ_INSERT;
    else if (pick < insert_pct + remove_pct) r.req_type = rsm_pkg::REQ_REMOVE;
    else if (pick < 98) r.req_type = rsm_pkg::REQ_SAMPLE;
    else r.req_type = REQ_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 55 && occupied_count > 0) begin
      r.item_value = stored_entries[$urandom_range(0, occupied_count - 1)];
    end else if (pick < 80) begin
      r.item_value = int'($urandom_range(0, 6)) - 3;
    end else begin
      r.item_value = $urandom;
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) r.random_word = '0;
    else if (pick == 1) r.random_word = '1;
    else r.random_word = $urandom;
    return r;
  endfunction

  task automatic send_request(rsm_pkg::req_t r);
    int gap;
    gap = $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req   = r;
    do @(posedge clk_i); while (busy);
    expected_results = {expected_results, multiset_apply(r)};
  endtask

  always @(posedge clk_i) begin : result_check
    rsm_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no request pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.hit_flag !== want.hit_flag) begin
          $error("hit_flag: expected %0d, actual %0d", want.hit_flag, res_o.hit_flag);
          mismatch_count++;
        end
        if (res_o.sampled_value !== want.sampled_value) begin
          $error("sampled_value: expected %0d, actual %0d",
                 want.sampled_value, res_o.sampled_value);
          mismatch_count++;
        end
        if (res_o.status_code !== want.status_code) begin
          $error("status_code: expected %0d, actual %0d",
                 want.status_code, res_o.status_code);
          mismatch_count++;
        end
        if (res_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, res_o.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("random_sample_multiset verification failed");
      $finish;
    end
  end

  task automatic test_empty_store();
    send_request(make_request(rsm_pkg::REQ_SAMPLE, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_REMOVE, 32'sd5, 32'hFFFF_FFFF));
    send_request(make_request(REQ_UNUSED, 32'sd0, 32'h0000_0000));
  endtask

  task automatic test_value_extremes();
    send_request(make_request(rsm_pkg::REQ_INSERT, 32'h8000_0000, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(rsm_pkg::REQ_INSERT, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_INSERT, -32'sd1, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_SAMPLE, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(rsm_pkg::REQ_SAMPLE, -32'sd1, 32'h0000_0001));
    send_request(make_request(rsm_pkg::REQ_SAMPLE, 32'h8000_0000, 32'h0000_0002));
  endtask

  task automatic test_duplicates_and_removal();
    send_request(make_request(rsm_pkg::REQ_INSERT, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_REMOVE, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_REMOVE, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_REMOVE, 32'sd0, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_REMOVE, 32'h8000_0000, 32'h0000_0000));
    send_request(make_request(rsm_pkg::REQ_SAMPLE, 32'sd0, 32'h0000_0003));
    send_request(make_request(REQ_UNUSED, -32'sd1, 32'hFFFF_FFFF));
  endtask

  task automatic test_fill_to_capacity();
    while (occupied_count < rsm_pkg::CAPACITY) send_request(random_request(85, 5));
    repeat (15) send_request(random_request(80, 0));
  endtask

  task automatic test_drain_to_empty();
    while (occupied_count > 0) send_request(random_request(5, 85));
    repeat (5) send_request(random_request(0, 0));
  endtask

  task automatic test_random_mix();
    int insert_pct;
    for (int round = 0; round < 10; round++) begin
      insert_pct = 25 * $urandom_range(1, 3);
      repeat (110) send_request(random_request(insert_pct, 90 - insert_pct));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_store();
    test_value_extremes();
    test_duplicates_and_removal();
    test_fill_to_capacity();
    test_drain_to_empty();
    test_random_mix();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("random_sample_multiset verification clean");
    end else begin
      $display("random_sample_multiset verification failed");
    end
    $finish;
  end

endmodule

[random_sample_multiset.f]
design/rsm_pkg.sv
design/rsm_ctrl.sv
design/rsm_dpath.sv
design/random_sample_multiset.sv
verif/random_sample_multiset_tb.sv
